/* src/das_pkg.sv */
// ----------------------------------------------------------------------------
// das_pkg: shared types and codes of the deadline admission scheduler
// Kind, rejection, event and stop codes, register indexes and the control
// and status bundles that pass between the top level and its cells.
// ----------------------------------------------------------------------------
package das_pkg;

    localparam int IdW   = 32;
    localparam int TimeW = 48;

    localparam logic [TimeW-1:0] TIME_NEVER = {TimeW{1'b1}};

    // request kinds
    localparam logic [2:0] KIND_ADMIT  = 3'd0;
    localparam logic [2:0] KIND_EXPIRE = 3'd1;
    localparam logic [2:0] KIND_START  = 3'd2;
    localparam logic [2:0] KIND_CANCEL = 3'd3;
    localparam logic [2:0] KIND_RETIRE = 3'd4;
    localparam logic [2:0] KIND_QUERY  = 3'd5;

    // rejection codes
    localparam logic [2:0] REJ_NONE      = 3'd0;
    localparam logic [2:0] REJ_INVALID   = 3'd1;
    localparam logic [2:0] REJ_DUPLICATE = 3'd2;
    localparam logic [2:0] REJ_CONTEXT   = 3'd3;
    localparam logic [2:0] REJ_FULL      = 3'd4;
    localparam logic [2:0] REJ_NOT_READY = 3'd5;
    localparam logic [2:0] REJ_DRAINING  = 3'd6;
    localparam logic [2:0] REJ_OVERFLOW  = 3'd7;

    // event codes
    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_Q_EXPIRED   = 3'd1;
    localparam logic [2:0] EV_RUN_DEADLINE = 3'd2;
    localparam logic [2:0] EV_STARTED     = 3'd3;
    localparam logic [2:0] EV_Q_CANCELLED = 3'd4;
    localparam logic [2:0] EV_RUN_CANCEL  = 3'd5;

    // stop reasons
    localparam logic [1:0] STOP_NONE      = 2'd0;
    localparam logic [1:0] STOP_DEADLINE  = 2'd1;
    localparam logic [1:0] STOP_CANCELLED = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_CONTEXT = 2'd0;
    localparam logic [1:0] REG_DEFAULT_DL  = 2'd1;
    localparam logic [1:0] REG_READY       = 2'd2;
    localparam logic [1:0] REG_DRAIN       = 2'd3;

    // one result record, counts and last are added at the output
    typedef struct packed {
        logic             accepted;
        logic             started;
        logic             slot_valid;
        logic [3:0]       slot;
        logic [2:0]       rejection;
        logic [IdW-1:0]   event_id;
        logic [2:0]       event_kind;
        logic             retired;
        logic [1:0]       stop_code;
    } t_rec;

    typedef struct packed {
        logic shift;
        logic load;
    } t_qctl;

    typedef struct packed {
        logic hit;
        logic due;
    } t_qsts;

    typedef struct packed {
        logic       fill;
        logic       stop_set;
        logic [1:0] stop_val;
        logic       free;
    } t_sctl;

    typedef struct packed {
        logic       busy;
        logic       hit;
        logic       due;
        logic [1:0] stop;
    } t_ssts;

endpackage

/* src/deadline_admission_scheduler.sv */
// ----------------------------------------------------------------------------
// deadline_admission_scheduler: admission control with wait queue and slots
// Requests enter on the slave stream (kind in tuser, fields in tdata); each
// gives one or more result records on the master stream, the final one with
// tlast set. Configuration is a plain write port, used while idle.
//
// One request at a time. After its transfer an admit, cancel, retire or
// query request passes through the execute state. Expire and start ready
// first drop due queue entries in the drop state; expire then marks slots
// whose deadline has passed, and start ready moves queue heads into free
// slots. Results then go out one per cycle while the receiver takes them;
// a stalled receiver holds the current record and the block accepts no new
// request until the last record is taken. The expiry scan is the queue cell
// chain, which removes one entry a cycle and compacts by shifting every
// higher cell down one place.
// Reset empties the queue and all slots and restores the register defaults.
// ----------------------------------------------------------------------------
module deadline_admission_scheduler #(
    parameter int WAIT_DEPTH = 8,
    parameter int SLOT_COUNT = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request_id[31:0] now_time[79:32] prompt_len[99:80] output_len[119:100]
    // deadline_len[151:120]
    input  logic [151:0] i_s_tdata,
    // kind[2:0]
    input  logic [2:0]   i_s_tuser,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // accepted[0] started[1] slot_valid[2] slot[6:3] rejection[9:7]
    // event_id[41:10] event_kind[44:42] retired[45] stop_code[47:46]
    // running_count[52:48] queued_count[58:53]
    output logic [63:0]  o_m_tdata,
    output logic         o_m_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);
    import das_pkg::*;

    localparam int QW   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FW   = $clog2(WAIT_DEPTH + 1);
    localparam int SW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RW   = $clog2(SLOT_COUNT + 1);
    localparam int NMAX = WAIT_DEPTH + SLOT_COUNT;
    localparam int BW   = $clog2(NMAX);
    localparam int NW   = $clog2(NMAX + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_QDROP = 3'd2;
    localparam logic [2:0] ST_SDEAD = 3'd3;
    localparam logic [2:0] ST_START = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // configuration
    logic [20:0] r_max_ctx;
    logic [31:0] r_def_dl;
    logic        r_ready;
    logic        r_drain;

    // captured request
    logic [2:0]       r_kind;
    logic [IdW-1:0]   r_id;
    logic [TimeW-1:0] r_now;
    logic [19:0]      r_plen;
    logic [19:0]      r_olen;
    logic [31:0]      r_dlen;

    logic [2:0]    r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    logic [RW-1:0] r_run, n_run;
    logic [NW-1:0] r_n, n_n;
    logic [NW-1:0] r_rd, n_rd;
    t_rec          r_buf [NMAX];

    // queue cell chain
    t_qctl            q_ctl [WAIT_DEPTH];
    t_qsts            q_sts [WAIT_DEPTH];
    logic [IdW-1:0]   q_id  [WAIT_DEPTH];
    logic [TimeW-1:0] q_exp [WAIT_DEPTH];

    // slot row
    t_sctl          s_ctl [SLOT_COUNT];
    t_ssts          s_sts [SLOT_COUNT];
    logic [IdW-1:0] s_id  [SLOT_COUNT];

    // control from the sequencer
    logic             wr_en;
    t_rec             wr_rec;
    logic             rm_en;
    logic [QW-1:0]    rm_idx;
    logic             push;
    logic [TimeW-1:0] ld_exp;
    logic [IdW-1:0]   ld_id;
    logic             sf_en;
    logic [SW-1:0]    sf_idx;
    logic             ss_en;
    logic [SW-1:0]    ss_idx;
    logic [1:0]       ss_val;
    logic             sr_en;
    logic [SW-1:0]    sr_idx;

    // scan results
    logic          qdue_any, qhit_any;
    logic [QW-1:0] qdue_idx, qhit_idx;
    logic          free_any, hit_any, sdue_any;
    logic [SW-1:0] free_idx, hit_idx, sdue_idx;

    // admit checks
    logic [20:0]      ctx_sum;
    logic [31:0]      dur;
    logic [TimeW-1:0] dur_lim;
    logic [TimeW-1:0] adm_exp;
    logic             adm_start;
    logic             adm_push;
    logic [2:0]       adm_rej;

    t_rec out_rec;
    logic out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ctx <= 21'h1FFFFF;
            r_def_dl  <= '0;
            r_ready   <= 1'b0;
            r_drain   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MAX_CONTEXT: r_max_ctx <= i_cfg_wdata[20:0];
                REG_DEFAULT_DL:  r_def_dl  <= i_cfg_wdata;
                REG_READY:       r_ready   <= i_cfg_wdata[0];
                REG_DRAIN:       r_drain   <= i_cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_kind <= i_s_tuser;
            r_id   <= i_s_tdata[31:0];
            r_now  <= i_s_tdata[79:32];
            r_plen <= i_s_tdata[99:80];
            r_olen <= i_s_tdata[119:100];
            r_dlen <= i_s_tdata[151:120];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < WAIT_DEPTH; gi++) begin : g_q
            logic [IdW-1:0]   nxt_id;
            logic [TimeW-1:0] nxt_exp;
            if (gi == WAIT_DEPTH - 1) begin : g_end
                assign nxt_id  = q_id[gi];
                assign nxt_exp = q_exp[gi];
            end else begin : g_mid
                assign nxt_id  = q_id[gi+1];
                assign nxt_exp = q_exp[gi+1];
            end
            assign q_ctl[gi].shift = rm_en && (QW'(gi) >= rm_idx);
            assign q_ctl[gi].load  = push && (QW'(gi) == r_fill[QW-1:0]);
            das_qcell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (q_ctl[gi]),
                .i_load_id  (r_id),
                .i_load_exp (adm_exp),
                .i_next_id  (nxt_id),
                .i_next_exp (nxt_exp),
                .i_key_id   (r_id),
                .i_now      (r_now),
                .o_id       (q_id[gi]),
                .o_exp      (q_exp[gi]),
                .o_sts      (q_sts[gi])
            );
        end
        for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_s
            assign s_ctl[gi].fill     = sf_en && (sf_idx == SW'(gi));
            assign s_ctl[gi].stop_set = ss_en && (ss_idx == SW'(gi));
            assign s_ctl[gi].stop_val = ss_val;
            assign s_ctl[gi].free     = sr_en && (sr_idx == SW'(gi));
            das_slot u_slot (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (s_ctl[gi]),
                .i_load_id  (ld_id),
                .i_load_exp (ld_exp),
                .i_key_id   (r_id),
                .i_now      (r_now),
                .o_id       (s_id[gi]),
                .o_sts      (s_sts[gi])
            );
        end
    endgenerate

    // lowest matching entry of each kind
    always_comb begin
        qdue_any = 1'b0;
        qdue_idx = '0;
        qhit_any = 1'b0;
        qhit_idx = '0;
        for (int i = WAIT_DEPTH - 1; i >= 0; i--) begin
            if (q_sts[i].due && (FW'(i) < r_fill)) begin
                qdue_any = 1'b1;
                qdue_idx = QW'(i);
            end
            if (q_sts[i].hit && (FW'(i) < r_fill)) begin
                qhit_any = 1'b1;
                qhit_idx = QW'(i);
            end
        end
    end

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        hit_any  = 1'b0;
        hit_idx  = '0;
        sdue_any = 1'b0;
        sdue_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!s_sts[i].busy) begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
            if (s_sts[i].hit) begin
                hit_any = 1'b1;
                hit_idx = SW'(i);
            end
            if (s_sts[i].due) begin
                sdue_any = 1'b1;
                sdue_idx = SW'(i);
            end
        end
    end

    always_comb begin
        ctx_sum   = {1'b0, r_plen} + {1'b0, r_olen};
        dur       = (r_dlen != '0) ? r_dlen : r_def_dl;
        dur_lim   = TIME_NEVER - TimeW'(dur);
        adm_exp   = (dur == '0) ? TIME_NEVER : r_now + TimeW'(dur);
        adm_start = 1'b0;
        adm_push  = 1'b0;
        if (!r_ready) begin
            adm_rej = REJ_NOT_READY;
        end else if (r_drain) begin
            adm_rej = REJ_DRAINING;
        end else if (r_id == '0) begin
            adm_rej = REJ_INVALID;
        end else if (qhit_any || hit_any) begin
            adm_rej = REJ_DUPLICATE;
        end else if (ctx_sum > r_max_ctx) begin
            adm_rej = REJ_CONTEXT;
        end else if ((dur != '0) && (r_now > dur_lim)) begin
            adm_rej = REJ_OVERFLOW;
        end else if ((r_fill == '0) && free_any) begin
            adm_rej   = REJ_NONE;
            adm_start = 1'b1;
        end else if (r_fill >= FW'(WAIT_DEPTH)) begin
            adm_rej = REJ_FULL;
        end else begin
            adm_rej  = REJ_NONE;
            adm_push = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_run   = r_run;
        n_rd    = r_rd;
        n_n     = r_n;
        wr_en   = 1'b0;
        wr_rec  = '0;
        rm_en   = 1'b0;
        rm_idx  = '0;
        push    = 1'b0;
        ld_id   = r_id;
        ld_exp  = adm_exp;
        sf_en   = 1'b0;
        sf_idx  = free_idx;
        ss_en   = 1'b0;
        ss_idx  = '0;
        ss_val  = STOP_NONE;
        sr_en   = 1'b0;
        sr_idx  = hit_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_n  = '0;
                    n_rd = '0;
                    if (i_s_tuser == KIND_EXPIRE || i_s_tuser == KIND_START) begin
                        n_state = ST_QDROP;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                n_state = ST_OUT;
                priority case (r_kind)
                    KIND_ADMIT: begin
                        wr_en             = 1'b1;
                        wr_rec.rejection  = adm_rej;
                        wr_rec.accepted   = adm_start || adm_push;
                        wr_rec.started    = adm_start;
                        wr_rec.slot_valid = adm_start;
                        wr_rec.slot       = adm_start ? 4'(free_idx) : 4'd0;
                        if (adm_start) begin
                            sf_en = 1'b1;
                            n_run = r_run + RW'(1);
                        end
                        if (adm_push) begin
                            push   = 1'b1;
                            n_fill = r_fill + FW'(1);
                        end
                    end
                    KIND_CANCEL: begin
                        if (qhit_any) begin
                            rm_en             = 1'b1;
                            rm_idx            = qhit_idx;
                            n_fill            = r_fill - FW'(1);
                            wr_en             = 1'b1;
                            wr_rec.event_id   = r_id;
                            wr_rec.event_kind = EV_Q_CANCELLED;
                        end else if (hit_any && s_sts[hit_idx].stop == STOP_NONE) begin
                            ss_en             = 1'b1;
                            ss_idx            = hit_idx;
                            ss_val            = STOP_CANCELLED;
                            wr_en             = 1'b1;
                            wr_rec.event_id   = r_id;
                            wr_rec.event_kind = EV_RUN_CANCEL;
                            wr_rec.slot_valid = 1'b1;
                            wr_rec.slot       = 4'(hit_idx);
                        end
                    end
                    KIND_RETIRE: begin
                        wr_en          = 1'b1;
                        wr_rec.retired = hit_any;
                        if (hit_any) begin
                            sr_en = 1'b1;
                            n_run = r_run - RW'(1);
                        end
                    end
                    KIND_QUERY: begin
                        wr_en            = 1'b1;
                        wr_rec.stop_code = hit_any ? s_sts[hit_idx].stop : STOP_NONE;
                    end
                    default: begin
                    end
                endcase
            end
            ST_QDROP: begin
                if (qdue_any) begin
                    rm_en             = 1'b1;
                    rm_idx            = qdue_idx;
                    n_fill            = r_fill - FW'(1);
                    wr_en             = 1'b1;
                    wr_rec.event_id   = q_id[qdue_idx];
                    wr_rec.event_kind = EV_Q_EXPIRED;
                end else if (r_kind == KIND_EXPIRE) begin
                    n_state = ST_SDEAD;
                end else begin
                    n_state = ST_START;
                end
            end
            ST_SDEAD: begin
                if (sdue_any) begin
                    ss_en             = 1'b1;
                    ss_idx            = sdue_idx;
                    ss_val            = STOP_DEADLINE;
                    wr_en             = 1'b1;
                    wr_rec.event_id   = s_id[sdue_idx];
                    wr_rec.event_kind = EV_RUN_DEADLINE;
                    wr_rec.slot_valid = 1'b1;
                    wr_rec.slot       = 4'(sdue_idx);
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_START: begin
                if ((r_fill != '0) && free_any) begin
                    // head of the queue moves into the lowest free slot
                    ld_id             = q_id[0];
                    ld_exp            = q_exp[0];
                    sf_en             = 1'b1;
                    n_run             = r_run + RW'(1);
                    rm_en             = 1'b1;
                    n_fill            = r_fill - FW'(1);
                    wr_en             = 1'b1;
                    wr_rec.event_id   = q_id[0];
                    wr_rec.event_kind = EV_STARTED;
                    wr_rec.slot_valid = 1'b1;
                    wr_rec.slot       = 4'(free_idx);
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_m_tready) begin
                    if (out_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rd = r_rd + NW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // events past the buffer still act but are not reported
        if (wr_en && (r_n < NW'(NMAX))) begin
            n_n = r_n + NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_run   <= '0;
            r_n     <= '0;
            r_rd    <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_run   <= n_run;
            r_n     <= n_n;
            r_rd    <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && (r_n < NW'(NMAX))) begin
            r_buf[r_n[BW-1:0]] <= wr_rec;
        end
    end

    // no record at all gives a single empty record
    assign out_rec  = (r_n == '0) ? '0 : r_buf[r_rd[BW-1:0]];
    assign out_last = (r_n == '0) || (r_rd == r_n - NW'(1));

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_OUT);
    assign o_m_tlast  = out_last;
    assign o_m_tdata  = {5'd0, 6'(r_fill), 5'(r_run), out_rec.stop_code,
                         out_rec.retired, out_rec.event_kind, out_rec.event_id,
                         out_rec.rejection, out_rec.slot, out_rec.slot_valid,
                         out_rec.started, out_rec.accepted};

endmodule

/* src/das_qcell.sv */
// ----------------------------------------------------------------------------
// das_qcell: one wait queue entry
// Holds an id and expiry, loads a new entry or takes its upper neighbor's
// entry when the queue compacts, and flags id match and timeout.
// ----------------------------------------------------------------------------
module das_qcell (
    input  logic                          i_clk,
    input  das_pkg::t_qctl                i_ctl,
    input  logic [das_pkg::IdW-1:0]       i_load_id,
    input  logic [das_pkg::TimeW-1:0]     i_load_exp,
    input  logic [das_pkg::IdW-1:0]       i_next_id,
    input  logic [das_pkg::TimeW-1:0]     i_next_exp,
    input  logic [das_pkg::IdW-1:0]       i_key_id,
    input  logic [das_pkg::TimeW-1:0]     i_now,
    output logic [das_pkg::IdW-1:0]       o_id,
    output logic [das_pkg::TimeW-1:0]     o_exp,
    output das_pkg::t_qsts                o_sts
);
    import das_pkg::*;

    logic [IdW-1:0]   r_id;
    logic [TimeW-1:0] r_exp;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_id  <= i_load_id;
            r_exp <= i_load_exp;
        end else if (i_ctl.shift) begin
            r_id  <= i_next_id;
            r_exp <= i_next_exp;
        end
    end

    assign o_id      = r_id;
    assign o_exp     = r_exp;
    assign o_sts.hit = (r_id == i_key_id);
    assign o_sts.due = (r_exp != TIME_NEVER) && (r_exp <= i_now);

endmodule

/* src/das_slot.sv */
// ----------------------------------------------------------------------------
// das_slot: one run slot
// Busy flag, id, expiry and stop reason of a running request, with id match
// and a flag for a deadline that has passed and is not yet marked.
// ----------------------------------------------------------------------------
module das_slot (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  das_pkg::t_sctl                i_ctl,
    input  logic [das_pkg::IdW-1:0]       i_load_id,
    input  logic [das_pkg::TimeW-1:0]     i_load_exp,
    input  logic [das_pkg::IdW-1:0]       i_key_id,
    input  logic [das_pkg::TimeW-1:0]     i_now,
    output logic [das_pkg::IdW-1:0]       o_id,
    output das_pkg::t_ssts                o_sts
);
    import das_pkg::*;

    logic             r_busy;
    logic [1:0]       r_stop;
    logic [IdW-1:0]   r_id;
    logic [TimeW-1:0] r_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_stop <= STOP_NONE;
        end else if (i_ctl.fill) begin
            r_busy <= 1'b1;
            r_stop <= STOP_NONE;
        end else if (i_ctl.free) begin
            r_busy <= 1'b0;
            r_stop <= STOP_NONE;
        end else if (i_ctl.stop_set) begin
            r_stop <= i_ctl.stop_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fill) begin
            r_id  <= i_load_id;
            r_exp <= i_load_exp;
        end
    end

    assign o_id       = r_id;
    assign o_sts.busy = r_busy;
    assign o_sts.stop = r_stop;
    assign o_sts.hit  = r_busy && (r_id == i_key_id);
    assign o_sts.due  = r_busy && (r_stop == STOP_NONE) && (r_exp != TIME_NEVER)
                        && (r_exp <= i_now);

endmodule

/* tb/das_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// das_checker: scoreboard for the deadline admission scheduler
// Watches request, result and register-write transfers, keeps its own copy
// of queue, slots and registers, and compares every result field by field.
// ----------------------------------------------------------------------------
module das_checker #(
    parameter int QDEPTH = 8,
    parameter int NSLOT  = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [151:0] i_s_tdata,
    input  logic [2:0]   i_s_tuser,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [63:0]  i_m_tdata,
    input  logic         i_m_tlast,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata,
    output int           o_errors,
    output int           o_pending
);
    import das_pkg::*;

    typedef struct packed {
        logic        last;
        logic [5:0]  queued;
        logic [4:0]  running;
        logic [1:0]  stop;
        logic        retired;
        logic [2:0]  ekind;
        logic [31:0] eid;
        logic [2:0]  rej;
        logic [3:0]  slot;
        logic        svalid;
        logic        started;
        logic        acc;
    } t_result;

    localparam int MaxEv = QDEPTH + NSLOT;

    logic [20:0] max_ctx;
    logic [31:0] dflt_dl;
    logic        ready_r, drain_r;
    logic [31:0] q_id [QDEPTH];
    logic [47:0] q_exp [QDEPTH];
    int          q_fill;
    logic        s_busy [NSLOT];
    logic [31:0] s_id [NSLOT];
    logic [47:0] s_exp [NSLOT];
    logic [1:0]  s_stop [NSLOT];
    int          n_busy;
    t_result     expected_q [$];
    t_result     batch [$];

    // queue kept compacted from index 0, same order as the cell chain
    function automatic bit is_due(logic [47:0] e, logic [47:0] now);
        return e != TIME_NEVER && e <= now;
    endfunction

    function automatic int first_idle();
        for (int s = 0; s < NSLOT; s++) if (!s_busy[s]) return s;
        return -1;
    endfunction

    task automatic q_drop(int off);
        for (int c = off; c + 1 < q_fill; c++) begin
            q_id[c] = q_id[c+1];
            q_exp[c] = q_exp[c+1];
        end
        q_fill--;
    endtask

    task automatic push_event(logic [31:0] id, logic [2:0] k, int s);
        t_result r;
        r = '0;
        if (batch.size() >= MaxEv) return;
        r.eid = id;
        r.ekind = k;
        if (s >= 0) begin
            r.svalid = 1'b1;
            r.slot = s[3:0];
        end
        batch.push_back(r);
    endtask

    task automatic predict_request(logic [2:0] kind, logic [151:0] d);
        logic [31:0] id, dl;
        logic [47:0] now, ex;
        logic [63:0] dur;
        t_result     r;
        int          s, off;
        bit          hit;
        id  = d[31:0];
        now = d[79:32];
        dl  = d[151:120];
        r = '0;
        batch.delete();
        case (kind)
            KIND_ADMIT: begin
                hit = 0;
                for (int i = 0; i < q_fill; i++) if (q_id[i] == id) hit = 1;
                for (int i = 0; i < NSLOT; i++) if (s_busy[i] && s_id[i] == id) hit = 1;
                dur = (dl != 0) ? 64'(dl) : 64'(dflt_dl);
                ex = TIME_NEVER;
                if (!ready_r) r.rej = REJ_NOT_READY;
                else if (drain_r) r.rej = REJ_DRAINING;
                else if (id == 0) r.rej = REJ_INVALID;
                else if (hit) r.rej = REJ_DUPLICATE;
                else if (22'(d[99:80]) + 22'(d[119:100]) > 22'(max_ctx)) r.rej = REJ_CONTEXT;
                else if (dur != 0 && 64'(now) > 64'(TIME_NEVER) - dur)
                    r.rej = REJ_OVERFLOW;
                if (r.rej == REJ_NONE) begin
                    if (dur != 0) ex = now + dur[47:0];
                    s = first_idle();
                    if (q_fill == 0 && s >= 0) begin
                        s_busy[s] = 1; s_id[s] = id; s_exp[s] = ex; s_stop[s] = STOP_NONE;
                        n_busy++;
                        r.acc = 1; r.started = 1; r.svalid = 1; r.slot = s[3:0];
                    end else if (q_fill >= QDEPTH) begin
                        r.rej = REJ_FULL;
                    end else begin
                        q_id[q_fill] = id; q_exp[q_fill] = ex; q_fill++;
                        r.acc = 1;
                    end
                end
                batch.push_back(r);
            end
            KIND_EXPIRE, KIND_START: begin
                off = 0;
                while (off < q_fill) begin
                    if (is_due(q_exp[off], now)) begin
                        push_event(q_id[off], EV_Q_EXPIRED, -1);
                        q_drop(off);
                    end else off++;
                end
                if (kind == KIND_EXPIRE) begin
                    for (int i = 0; i < NSLOT; i++)
                        if (s_busy[i] && s_stop[i] == STOP_NONE && is_due(s_exp[i], now)) begin
                            s_stop[i] = STOP_DEADLINE;
                            push_event(s_id[i], EV_RUN_DEADLINE, i);
                        end
                end else begin
                    while (q_fill != 0 && first_idle() >= 0) begin
                        s = first_idle();
                        s_busy[s] = 1; s_id[s] = q_id[0]; s_exp[s] = q_exp[0];
                        s_stop[s] = STOP_NONE;
                        n_busy++;
                        push_event(q_id[0], EV_STARTED, s);
                        q_drop(0);
                    end
                end
            end
            KIND_CANCEL: begin
                hit = 0;
                for (int i = 0; i < q_fill && !hit; i++)
                    if (q_id[i] == id) begin
                        q_drop(i);
                        push_event(id, EV_Q_CANCELLED, -1);
                        hit = 1;
                    end
                for (int i = 0; i < NSLOT && !hit; i++)
                    if (s_busy[i] && s_id[i] == id) begin
                        if (s_stop[i] == STOP_NONE) begin
                            s_stop[i] = STOP_CANCELLED;
                            push_event(id, EV_RUN_CANCEL, i);
                        end
                        hit = 1;
                    end
            end
            KIND_RETIRE: begin
                for (int i = 0; i < NSLOT; i++)
                    if (s_busy[i] && s_id[i] == id) begin
                        s_busy[i] = 0; s_stop[i] = STOP_NONE; n_busy--;
                        r.retired = 1;
                        break;
                    end
                batch.push_back(r);
            end
            KIND_QUERY: begin
                for (int i = 0; i < NSLOT; i++)
                    if (s_busy[i] && s_id[i] == id) begin
                        r.stop = s_stop[i];
                        break;
                    end
                batch.push_back(r);
            end
            default: ;
        endcase
        if (batch.size() == 0) batch.push_back('0);
        foreach (batch[k]) begin
            batch[k].running = 5'(n_busy);
            batch[k].queued = 6'(q_fill);
            batch[k].last = (k == batch.size() - 1);
            expected_q.push_back(batch[k]);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            max_ctx <= 21'h1FFFFF;
            dflt_dl <= '0;
            ready_r <= 1'b0;
            drain_r <= 1'b0;
            q_fill = 0;
            n_busy = 0;
            for (int i = 0; i < NSLOT; i++) begin
                s_busy[i] = 0;
                s_stop[i] = STOP_NONE;
            end
            expected_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MAX_CONTEXT: max_ctx <= i_cfg_wdata[20:0];
                    REG_DEFAULT_DL:  dflt_dl <= i_cfg_wdata;
                    REG_READY:       ready_r <= i_cfg_wdata[0];
                    REG_DRAIN:       drain_r <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) predict_request(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tlast, i_m_tdata[58:0]};
                if (expected_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %h", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %h actual %h", want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

/* tb/tb_deadline_admission_scheduler.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_deadline_admission_scheduler: stimulus and verdict
// Drives directed and random requests under random stalls on both streams,
// changes the registers between phases, and reports the checker's outcome.
// ----------------------------------------------------------------------------
module tb_deadline_admission_scheduler;
    import das_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [151:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  m_tdata;
    logic         m_tlast, m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = '0;
    logic [31:0]  cfg_wdata = '0;
    int           errors, pending;
    int           cycles = 0;
    bit           sink_on = 1'b0;
    logic [31:0]  id_pool [8];
    logic [47:0]  clock_ms = 48'd1000;

    always #6 i_clk = ~i_clk;

    deadline_admission_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser), .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .o_m_tdata(m_tdata), .o_m_tlast(m_tlast), .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata)
    );

    das_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser), .i_s_tvalid(s_tvalid),
        .i_s_tready(s_tready),
        .i_m_tdata(m_tdata), .i_m_tlast(m_tlast), .i_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls, with stretches of always-ready
    always @(posedge i_clk) begin
        if (!sink_on) m_tready <= 1'b0;
        else if ((cycles / 300) % 4 == 0) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 99) < 60) || ($urandom_range(0, 99) < 3);
    end

    // valid stays up after a transfer so back-to-back items need no gap
    task automatic send(logic [2:0] kind, logic [31:0] id, logic [47:0] now,
                        logic [19:0] pl, logic [19:0] ol, logic [31:0] dl);
        int g;
        g = ((cycles / 500) % 3 == 0) ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_tuser  <= kind;
        s_tdata  <= {dl, ol, pl, now, id};
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain_wait();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] a, logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item(bit wild);
        logic [2:0]  k;
        logic [31:0] id, dl;
        logic [47:0] now;
        int          p;
        p = $urandom_range(0, 99);
        k = p < 40 ? KIND_ADMIT : p < 52 ? KIND_EXPIRE : p < 66 ? KIND_START :
            p < 76 ? KIND_CANCEL : p < 90 ? KIND_RETIRE : p < 98 ? KIND_QUERY :
            3'($urandom_range(6, 7));
        id = id_pool[$urandom_range(0, 7)];
        clock_ms = clock_ms + 48'($urandom_range(0, 40));
        now = clock_ms;
        dl = $urandom_range(0, 3) == 0 ? 32'd0 : 32'($urandom_range(5, 200));
        if (wild) begin
            id = $urandom_range(0, 9) == 0 ? 32'd0 : $urandom;
            now = 48'({$urandom, $urandom});
            dl = $urandom;
        end
        send(k, id, now, 20'($urandom_range(0, 30000)), 20'($urandom_range(0, 30000)), dl);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_on = 1'b1;
        foreach (id_pool[i]) id_pool[i] = i == 7 ? 32'hFFFF_FFFF : 32'(i + 1);

        // not ready, then draining
        send(KIND_ADMIT, 32'd1, 48'd0, 20'd0, 20'd0, 32'd0);
        send(3'd6, 32'd0, 48'd0, 20'd0, 20'd0, 32'd0);
        drain_wait();
        write_reg(REG_READY, 32'd1);
        write_reg(REG_DRAIN, 32'd1);
        send(KIND_ADMIT, 32'd1, 48'd0, 20'd0, 20'd0, 32'd0);
        drain_wait();
        write_reg(REG_DRAIN, 32'd0);
        write_reg(REG_MAX_CONTEXT, 32'd1000);
        write_reg(REG_DEFAULT_DL, 32'hFFFF_FFFF);
        send(KIND_ADMIT, 32'd0, 48'd0, 20'd0, 20'd0, 32'd0);
        send(KIND_ADMIT, 32'd1, 48'd100, 20'd500, 20'd501, 32'd10);
        send(KIND_ADMIT, 32'd1, 48'hFFFF_FFFF_FFFF, 20'd0, 20'd0, 32'd1);
        send(KIND_ADMIT, 32'd1, 48'd100, 20'd500, 20'd500, 32'd10);
        send(KIND_ADMIT, 32'd1, 48'd100, 20'd0, 20'd0, 32'd10);
        send(KIND_ADMIT, 32'hFFFF_FFFF, 48'd100, 20'd0, 20'd0, 32'd0);
        for (int i = 2; i < 14; i++)
            send(KIND_ADMIT, 32'(i), 48'd100, 20'd1, 20'd1, 32'(i * 10));
        send(KIND_QUERY, 32'd1, 48'd0, 20'd0, 20'd0, 32'd0);
        send(KIND_CANCEL, 32'd2, 48'd0, 20'd0, 20'd0, 32'd0);
        send(KIND_CANCEL, 32'd2, 48'd0, 20'd0, 20'd0, 32'd0);
        send(KIND_CANCEL, 32'd9, 48'd0, 20'd0, 20'd0, 32'd0);
        send(KIND_QUERY, 32'd2, 48'd0, 20'd0, 20'd0, 32'd0);
        send(KIND_EXPIRE, 32'd0, 48'hFFFF_FFFF_FFFE, 20'd0, 20'd0, 32'd0);
        send(KIND_RETIRE, 32'd2, 48'd0, 20'd0, 20'd0, 32'd0);
        send(KIND_RETIRE, 32'd77, 48'd0, 20'd0, 20'd0, 32'd0);
        send(KIND_START, 32'd0, 48'hFFFF_FFFF_FFFF, 20'd0, 20'd0, 32'd0);
        drain_wait();
        write_reg(REG_MAX_CONTEXT, 32'h1F_FFFF);
        write_reg(REG_DEFAULT_DL, 32'd0);
        send(KIND_ADMIT, 32'd500, 48'd0, 20'hF_FFFF, 20'hF_FFFF, 32'd0);
        drain_wait();
        write_reg(REG_DEFAULT_DL, 32'd60);
        write_reg(REG_MAX_CONTEXT, 32'd40000);

        // random phases: mostly well-formed traffic on a small id pool
        for (int ph = 0; ph < 6; ph++) begin
            for (int n = 0; n < 70; n++) random_item($urandom_range(0, 9) == 0);
            drain_wait();
            write_reg(REG_DEFAULT_DL, ph == 2 ? 32'd0 : 32'($urandom_range(20, 300)));
            write_reg(REG_DRAIN, ph == 3 ? 32'd1 : 32'd0);
            write_reg(REG_READY, ph == 4 ? 32'd0 : 32'd1);
            write_reg(REG_MAX_CONTEXT, ph == 1 ? 32'd0 : 32'($urandom_range(20000, 60000)));
        end
        drain_wait();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
